// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk while reset is released.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that cons holds in the cycle after ante, outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/esd_pkg.sv -----
package esd_pkg;

    localparam int CNT_W = 16;
    localparam int EXT_W = (CNT_W > 16) ? CNT_W : 16;

    localparam logic [15:0] MAX_LEN_RST = 16'd1024;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X_LO   = 8'h78;

    localparam logic [1:0] OCT_DIGITS = 2'd3;
    localparam logic [1:0] HEX_DIGITS = 2'd2;

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_OCT   = 2'd1,
        MODE_HEX   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_FULL = 2'd1,
        KIND_DONE = 2'd2,
        KIND_ERR  = 2'd3
    } kind_t;

    typedef struct packed {
        mode_t             mode;
        logic [1:0]        seen;
        logic [8:0]        value;
        logic [CNT_W-1:0]  bytes;
        logic [CNT_W-1:0]  cidx;
        logic              dropping;
    } dec_state_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [7:0]  out_byte;
        logic [15:0] count_or_pos;
    } dec_result_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
    endfunction

    function automatic logic [15:0] sat16(input logic [CNT_W-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        return (ext > EXT_W'(16'hFFFF)) ? 16'hFFFF : ext[15:0];
    endfunction

endpackage

// ----- rtl/core/esd_step.sv -----
module esd_step (
    input  logic [7:0]              ch,
    input  logic [15:0]             max_out_len,
    input  esd_pkg::dec_state_t     cur,
    output esd_pkg::dec_state_t     nxt,
    output esd_pkg::dec_result_t    res
);
    import esd_pkg::*;

    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] bytes_inc;
    logic             do_emit;
    logic [7:0]       emit_val;
    logic             do_err;
    logic             digit_ok;
    logic [3:0]       digit;
    logic [8:0]       value_new;
    logic [1:0]       seen_new;
    logic [1:0]       needed;

    always_comb begin
        idx       = sat_inc(cur.cidx);
        bytes_inc = sat_inc(cur.bytes);
        needed    = (cur.mode == MODE_HEX) ? HEX_DIGITS : OCT_DIGITS;
        seen_new  = cur.seen + 2'd1;

        // Digit decode for the open escape.
        digit    = 4'd0;
        digit_ok = 1'b0;
        if (cur.mode == MODE_HEX) begin
            if (ch inside {[8'h30:8'h39]}) begin
                digit    = ch[3:0];
                digit_ok = 1'b1;
            end else if (ch inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
                digit    = ch[3:0] + 4'd9;
                digit_ok = 1'b1;
            end
            value_new = {cur.value[4:0], digit};
        end else begin
            if (ch inside {[8'h30:8'h37]}) begin
                digit    = {1'b0, ch[2:0]};
                digit_ok = 1'b1;
            end
            value_new = {cur.value[5:0], digit[2:0]};
        end

        nxt      = cur;
        res      = '0;
        res.kind = KIND_BYTE;
        do_emit  = 1'b0;
        do_err   = 1'b0;
        emit_val = ch;

        if (ch == CH_NUL) begin
            if (!cur.dropping) begin
                res.valid = 1'b1;
                if (cur.mode != MODE_PLAIN) begin
                    res.kind         = KIND_ERR;
                    res.count_or_pos = sat16(cur.cidx);
                end else begin
                    res.kind         = KIND_DONE;
                    res.count_or_pos = sat16(cur.bytes);
                end
            end
            nxt = '0;
        end else if (!cur.dropping) begin
            nxt.cidx = idx;
            if (cur.mode == MODE_PLAIN) begin
                if (ch == CH_BSLASH) begin
                    nxt.mode  = MODE_OCT;
                    nxt.seen  = 2'd0;
                    nxt.value = 9'd0;
                end else begin
                    do_emit = 1'b1;
                end
            end else if (ch == CH_X_LO) begin
                if (cur.seen != 2'd0) begin
                    do_err = 1'b1;
                end else begin
                    nxt.mode = MODE_HEX;
                end
            end else if (ch == CH_BSLASH) begin
                do_emit = 1'b1;
            end else if (!digit_ok) begin
                do_err = 1'b1;
            end else if (seen_new == needed) begin
                do_emit  = 1'b1;
                emit_val = value_new[7:0];
            end else begin
                nxt.value = value_new;
                nxt.seen  = seen_new;
            end

            if (do_emit) begin
                nxt.mode     = MODE_PLAIN;
                nxt.seen     = 2'd0;
                nxt.value    = 9'd0;
                nxt.bytes    = bytes_inc;
                res.valid    = 1'b1;
                res.out_byte = emit_val;
                if (EXT_W'(bytes_inc) >= EXT_W'(max_out_len)) begin
                    nxt.dropping     = 1'b1;
                    res.kind         = KIND_FULL;
                    res.count_or_pos = sat16(bytes_inc);
                end
            end
            if (do_err) begin
                nxt.mode         = MODE_PLAIN;
                nxt.seen         = 2'd0;
                nxt.value        = 9'd0;
                nxt.dropping     = 1'b1;
                res.valid        = 1'b1;
                res.kind         = KIND_ERR;
                res.count_or_pos = sat16(idx);
            end
        end
    end

endmodule

// ----- rtl/core/escape_sequence_decoder.sv -----
// Escape-sequence decoder: takes one character per request on the s_ side and
// gives at most one result per character on the m_ side. A zero character ends
// the string with a done result (byte count) or, if an escape is still open, an
// error at the string length. Backslash opens an escape: three octal digits,
// 'x' plus two hex digits, or a second backslash each give one byte. Bad digits
// and an 'x' after digits give an error with the 1-based character position;
// reaching max_out_len bytes gives a full result. After full or error, the rest
// of the string is dropped up to its terminator. One character is accepted every
// cycle while m_tready stays high. An accepted character is held in the input
// register, and one pass of decode logic loads its result into the result
// register, which drives m_tvalid. While a result waits on m_tready, a held
// character that makes no result still moves on, but one that makes a result
// holds the input register and drops s_tready until the waiting result is taken.
// Write cfg_wr_data only while the block is idle.
module escape_sequence_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: max_out_len
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // input characters
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] count_or_pos
    output logic [1:0]  m_tuser    // [1:0] kind
);
    import esd_pkg::*;

    `include "assert_macros.svh"

    logic [15:0]  max_len_reg;

    // Input register
    logic         in_valid_reg;
    logic [7:0]   ch_reg;

    // Decoder state
    dec_state_t   state_reg;
    dec_state_t   state_next;
    dec_result_t  step_res;

    // Result register
    logic         out_valid_reg;
    kind_t        kind_reg;
    logic [7:0]   byte_reg;
    logic [15:0]  count_reg;

    logic         advance;

    esd_step u_step (
        .ch          (ch_reg),
        .max_out_len (max_len_reg),
        .cur         (state_reg),
        .nxt         (state_next),
        .res         (step_res)
    );

    // Move the held character through decode when its result has room
    // (a character with no result never waits on the output side).
    assign advance  = in_valid_reg && (!step_res.valid || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RST;
        end else if (cfg_wr_en) begin
            max_len_reg <= cfg_wr_data;
        end
    end

    // Hold the accepted character until decode consumes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            ch_reg <= s_tdata;
        end
    end

    // Advance the decoder state one character at a time.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Load a new result or drop the taken one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && step_res.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && step_res.valid) begin
            kind_reg  <= step_res.kind;
            byte_reg  <= step_res.out_byte;
            count_reg <= step_res.count_or_pos;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {count_reg, byte_reg};
    assign m_tuser  = kind_reg;

    // A waiting result is never overwritten.
    `ASSERT_CLK(a_no_overwrite, aclk, aresetn,
        !(out_valid_reg && !m_tready && advance && step_res.valid),
        "result overwritten while waiting")

    // A decoded result shows up on the next cycle.
    `ASSERT_NEXT(a_result_shown, aclk, aresetn,
        advance && step_res.valid, m_tvalid,
        "decoded result not presented")

    // Dropping never leaves an escape open.
    `ASSERT_CLK(a_drop_plain, aclk, aresetn,
        !state_reg.dropping || state_reg.mode == MODE_PLAIN,
        "escape open while dropping")

    // A hex escape closes at its second digit.
    `ASSERT_CLK(a_hex_digits, aclk, aresetn,
        state_reg.mode != MODE_HEX || state_reg.seen < HEX_DIGITS,
        "hex digit count overrun")

    // Error positions are 1-based.
    `ASSERT_CLK(a_err_pos, aclk, aresetn,
        !(out_valid_reg && kind_reg == KIND_ERR) || count_reg != 16'd0,
        "error reported at position zero")

endmodule

// ----- tb/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import esd_pkg::*;

    // Extra cycles to let the pipeline empty out after the last result,
    // since characters that are dropped produce no result of their own.
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 8;
    // Minimum number of characters sent per random phase.
    localparam int PHASE_CHARS  = 145;

    // How a row of the directed script is checked.
    typedef enum logic [1:0] {
        CHK_MODEL,  // expectation comes from the decoder model below
        CHK_NONE,   // the character must not produce a result
        CHK_GIVEN   // the expectation is spelled out in the row
    } chk_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  out_byte;
        logic [15:0] count;
    } result_t;

    typedef struct {
        logic [7:0] ch;
        chk_t       how;
        result_t    given;
    } row_t;

    localparam result_t NO_RESULT = '0;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;     // [7:0] ch
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // [7:0] out_byte, [23:8] count_or_pos
    logic [1:0]  m_tuser;            // [1:0] kind

    escape_sequence_decoder u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #1 aclk = ~aclk;

    // Decoder model state, mirrored per string, plus the length limit.
    mode_t            p_mode;
    logic [1:0]       p_needed;
    logic [1:0]       p_seen;
    logic [8:0]       p_value;
    logic [CNT_W-1:0] p_bytes;
    logic [CNT_W-1:0] p_cidx;
    bit               p_drop;
    logic [15:0]      p_limit;

    result_t results_due[$];

    int unsigned tx_pct = 0;   // chance in 100 that the sender idles a cycle
    int unsigned rx_pct = 0;   // chance in 100 that the receiver stalls a cycle
    int unsigned n_sent = 0;
    int unsigned n_live = 0;
    int unsigned n_checked = 0;
    int unsigned n_fail = 0;

    // Directed script: reset limit (1024) is in force while it runs.
    row_t script [0:26] = '{
        // a plain letter and the top of the byte range, then the terminator
        '{"A",       CHK_GIVEN, '{KIND_BYTE, 8'h41, 16'd0}},
        '{8'hFF,     CHK_GIVEN, '{KIND_BYTE, 8'hFF, 16'd0}},
        '{CH_NUL,    CHK_GIVEN, '{KIND_DONE, 8'h00, 16'd2}},
        // empty string
        '{CH_NUL,    CHK_GIVEN, '{KIND_DONE, 8'h00, 16'd0}},
        // octal 400 keeps only its low byte
        '{CH_BSLASH, CHK_NONE,  NO_RESULT},
        '{"4",       CHK_NONE,  NO_RESULT},
        '{"0",       CHK_NONE,  NO_RESULT},
        '{"0",       CHK_MODEL, NO_RESULT},
        // a second x restarts the hex escape; mixed-case digits
        '{CH_BSLASH, CHK_NONE,  NO_RESULT},
        '{CH_X_LO,   CHK_NONE,  NO_RESULT},
        '{CH_X_LO,   CHK_NONE,  NO_RESULT},
        '{"A",       CHK_NONE,  NO_RESULT},
        '{"f",       CHK_MODEL, NO_RESULT},
        // backslash in the middle of an escape discards the digits
        '{CH_BSLASH, CHK_NONE,  NO_RESULT},
        '{"1",       CHK_NONE,  NO_RESULT},
        '{CH_BSLASH, CHK_MODEL, NO_RESULT},
        // x after a digit is an error at position 15
        '{CH_BSLASH, CHK_NONE,  NO_RESULT},
        '{"1",       CHK_NONE,  NO_RESULT},
        '{CH_X_LO,   CHK_GIVEN, '{KIND_ERR, 8'h00, 16'd15}},
        // terminator while dropping gives nothing
        '{CH_NUL,    CHK_NONE,  NO_RESULT},
        // upper-case X is not a hex digit
        '{CH_BSLASH, CHK_NONE,  NO_RESULT},
        '{CH_X_LO,   CHK_NONE,  NO_RESULT},
        '{"X",       CHK_GIVEN, '{KIND_ERR, 8'h00, 16'd3}},
        '{CH_NUL,    CHK_NONE,  NO_RESULT},
        // escape still open at the terminator: error at the string length
        '{CH_BSLASH, CHK_NONE,  NO_RESULT},
        '{"7",       CHK_NONE,  NO_RESULT},
        '{CH_NUL,    CHK_GIVEN, '{KIND_ERR, 8'h00, 16'd2}}
    };

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [15:0] clip16(input logic [CNT_W-1:0] v);
        return (v > 'hFFFF) ? 16'hFFFF : 16'(v);
    endfunction

    function automatic void clear_string();
        p_mode   = MODE_PLAIN;
        p_needed = 2'd0;
        p_seen   = 2'd0;
        p_value  = 9'd0;
        p_bytes  = '0;
        p_cidx   = '0;
        p_drop   = 1'b0;
    endfunction

    // Advance the decoder model by one character; return 1 when it
    // produces a result, which is then left in r.
    function automatic bit decode_char(input logic [7:0] c, output result_t r);
        logic [3:0] dig;
        logic [7:0] gb;
        bit         ok;
        bit         give_byte;
        bit         give_err;
        bit         live;
        r         = NO_RESULT;
        dig       = 4'd0;
        gb        = 8'd0;
        ok        = 1'b1;
        give_byte = 1'b0;
        give_err  = 1'b0;

        if (c == CH_NUL) begin
            live = !p_drop;
            if (live) begin
                if (p_mode != MODE_PLAIN) begin
                    r.kind  = KIND_ERR;
                    r.count = clip16(p_cidx);
                end else begin
                    r.kind  = KIND_DONE;
                    r.count = clip16(p_bytes);
                end
            end
            clear_string();
            return live;
        end
        if (p_drop)
            return 1'b0;

        p_cidx = bump(p_cidx);

        if (p_mode == MODE_PLAIN) begin
            if (c == CH_BSLASH) begin
                p_mode   = MODE_OCT;
                p_needed = OCT_DIGITS;
                p_seen   = 2'd0;
                p_value  = 9'd0;
                return 1'b0;
            end
            give_byte = 1'b1;
            gb        = c;
        end else if (c == CH_X_LO) begin
            if (p_seen != 2'd0) begin
                give_err = 1'b1;
            end else begin
                p_mode   = MODE_HEX;
                p_needed = HEX_DIGITS;
                return 1'b0;
            end
        end else if (c == CH_BSLASH) begin
            give_byte = 1'b1;
            gb        = c;
        end else begin
            if (p_mode == MODE_HEX) begin
                if (c >= "0" && c <= "9")
                    dig = 4'(c - "0");
                else if (c >= "A" && c <= "F")
                    dig = 4'(c - "A" + 8'd10);
                else if (c >= "a" && c <= "f")
                    dig = 4'(c - "a" + 8'd10);
                else
                    ok = 1'b0;
                if (ok)
                    p_value = {p_value[4:0], dig};
            end else begin
                if (c >= "0" && c <= "7")
                    p_value = {p_value[5:0], c[2:0]};
                else
                    ok = 1'b0;
            end
            if (!ok) begin
                give_err = 1'b1;
            end else begin
                p_seen = p_seen + 2'd1;
                if (p_seen == p_needed) begin
                    give_byte = 1'b1;
                    gb        = p_value[7:0];
                end
            end
        end

        if (give_err) begin
            p_mode  = MODE_PLAIN;
            p_seen  = 2'd0;
            p_value = 9'd0;
            p_drop  = 1'b1;
            r.kind  = KIND_ERR;
            r.count = clip16(p_cidx);
            return 1'b1;
        end
        if (give_byte) begin
            p_mode     = MODE_PLAIN;
            p_seen     = 2'd0;
            p_value    = 9'd0;
            p_bytes    = bump(p_bytes);
            r.out_byte = gb;
            if (p_bytes >= p_limit) begin
                p_drop  = 1'b1;
                r.kind  = KIND_FULL;
                r.count = clip16(p_bytes);
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] any_plain();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255, 1));
        while (c == CH_BSLASH);
        return c;
    endfunction

    function automatic logic [7:0] oct_char();
        return 8'("0" + $urandom_range(7));
    endfunction

    function automatic logic [7:0] hex_char();
        int unsigned v;
        v = $urandom_range(15);
        if (v < 10)
            return 8'("0" + v);
        return $urandom_range(1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
    endfunction

    // A character that is neither a digit of the open escape, nor x,
    // nor backslash, nor the terminator.
    function automatic logic [7:0] bad_char(input bit hex);
        logic [7:0] c;
        bit         digit;
        if (hex && $urandom_range(3) == 0)
            return "X";
        do begin
            c = 8'($urandom_range(255, 1));
            if (hex)
                digit = (c >= "0" && c <= "9") || (c >= "a" && c <= "f")
                        || (c >= "A" && c <= "F");
            else
                digit = (c >= "0" && c <= "7");
        end while (digit || c == CH_X_LO || c == CH_BSLASH);
        return c;
    endfunction

    // Present one character, wait for the request to be taken, and record
    // what the decoder should answer.
    task automatic send_char(input logic [7:0] c, input chk_t how, input result_t given);
        result_t r;
        bit      got;
        bit      ign;
        while (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do
            @(posedge aclk);
        while (!s_tready);
        n_sent++;
        ign = p_drop && (c != CH_NUL);
        if (!ign)
            n_live++;
        got = decode_char(c, r);
        case (how)
            CHK_MODEL: if (got) results_due.push_back(r);
            CHK_GIVEN: results_due.push_back(given);
            default: ;
        endcase
    endtask

    // Hold the sender off until every expected result has come back.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (results_due.size() != 0);
    endtask

    task automatic settle();
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        p_limit = v;
    endtask

    // One random string: mostly well-formed escapes and plain bytes, with
    // bad digits, late x, stray backslashes, raw noise and early cut-offs
    // mixed in. Always closed by a terminator.
    task automatic gen_string();
        logic [7:0] s[$];
        int unsigned nseg;
        int unsigned r;
        bit          cut;
        bit          hex;
        cut  = 1'b0;
        nseg = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(8);
        for (int i = 0; i < nseg && !cut; i++) begin
            r   = $urandom_range(99);
            hex = 1'($urandom_range(1));
            if (r < 35) begin
                s.push_back(any_plain());
            end else if (r < 50) begin
                s.push_back(CH_BSLASH);
                repeat (3) s.push_back(oct_char());
            end else if (r < 65) begin
                s.push_back(CH_BSLASH);
                s.push_back(CH_X_LO);
                repeat (2) s.push_back(hex_char());
            end else if (r < 70) begin
                s.push_back(CH_BSLASH);
                s.push_back(CH_BSLASH);
            end else if (r < 74) begin
                // x restart before the digits
                s.push_back(CH_BSLASH);
                s.push_back(CH_X_LO);
                s.push_back(CH_X_LO);
                repeat (2) s.push_back(hex_char());
            end else if (r < 78) begin
                // backslash closes a partial escape
                s.push_back(CH_BSLASH);
                if (hex) begin
                    s.push_back(CH_X_LO);
                    repeat ($urandom_range(1)) s.push_back(hex_char());
                end else begin
                    repeat ($urandom_range(2)) s.push_back(oct_char());
                end
                s.push_back(CH_BSLASH);
            end else if (r < 85) begin
                // bad digit
                s.push_back(CH_BSLASH);
                if (hex) begin
                    s.push_back(CH_X_LO);
                    repeat ($urandom_range(1)) s.push_back(hex_char());
                end else begin
                    repeat ($urandom_range(2)) s.push_back(oct_char());
                end
                s.push_back(bad_char(hex));
            end else if (r < 89) begin
                // x after digits
                s.push_back(CH_BSLASH);
                if (hex) begin
                    s.push_back(CH_X_LO);
                    s.push_back(hex_char());
                end else begin
                    repeat ($urandom_range(2, 1)) s.push_back(oct_char());
                end
                s.push_back(CH_X_LO);
            end else if (r < 95) begin
                s.push_back(8'($urandom_range(255)));
            end else begin
                // leave an escape open at the terminator
                s.push_back(CH_BSLASH);
                repeat ($urandom_range(2)) s.push_back(oct_char());
                cut = 1'b1;
            end
        end
        s.push_back(CH_NUL);
        foreach (s[i])
            send_char(s[i], CHK_MODEL, NO_RESULT);
    endtask

    // Receiver back-pressure: drop tready at random according to rx_pct.
    always @(posedge aclk) begin
        m_tready <= !(rx_pct != 0 && $urandom_range(99) < rx_pct);
    end

    // Result checker: compare each taken result with the oldest expectation.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                n_fail++;
                $display("%0t: unexpected result kind=%0d out_byte=%02h count=%0d",
                         $time, m_tuser, m_tdata[7:0], m_tdata[23:8]);
            end else begin
                want = results_due.pop_front();
                n_checked++;
                if (kind_t'(m_tuser) !== want.kind) begin
                    n_fail++;
                    $display("%0t: kind expected %0d actual %0d",
                             $time, want.kind, m_tuser);
                end
                if (m_tdata[7:0] !== want.out_byte) begin
                    n_fail++;
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, want.out_byte, m_tdata[7:0]);
                end
                if (m_tdata[23:8] !== want.count) begin
                    n_fail++;
                    $display("%0t: count_or_pos expected %0d actual %0d",
                             $time, want.count, m_tdata[23:8]);
                end
            end
        end
    end

    // Watchdog: the slowest correct run is far below this.
    initial begin
        #200_000;
        $display("escape_sequence_decoder regression: fail");
        $finish;
    end

    initial begin
        int unsigned ph_limit [PHASES];
        int unsigned ph_tx [PHASES];
        int unsigned ph_rx [PHASES];
        int unsigned start;
        int unsigned nstr;

        // Limits: one, zero, small random ones so strings fill up often,
        // the maximum, the reset value again, and a larger random one.
        ph_limit = '{1, 0, $urandom_range(40, 2), $urandom_range(40, 2), 65535,
                     $urandom_range(40, 2), 1024, $urandom_range(300, 41)};
        ph_tx    = '{0, 47, 0, 36, 0, 36, 47, 0};
        ph_rx    = '{0, 0, 47, 36, 0, 36, 0, 47};

        clear_string();
        p_limit = MAX_LEN_RST;

        // Hold reset, then release it for good.
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed script under the reset limit, no idling.
        foreach (script[i])
            send_char(script[i].ch, script[i].how, script[i].given);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_limit(ph_limit[p][15:0]);
            tx_pct = ph_tx[p];
            rx_pct = ph_rx[p];

            start = n_sent;
            nstr  = 0;
            while (n_sent - start < PHASE_CHARS) begin
                // Now and then let the output side run completely dry.
                if (nstr == 3 || $urandom_range(99) < 2)
                    hold_until_drained();
                gen_string();
                nstr++;
            end
        end

        settle();

        $display("Ran %0d characters (%0d decoded, rest dropped) under %0d length limits;",
                 n_sent, n_live, PHASES + 1);
        $display("compared %0d results, %0d mismatches, %0d still outstanding.",
                 n_checked, n_fail, results_due.size());
        if (n_fail == 0 && results_due.size() == 0)
            $display("escape_sequence_decoder regression: pass");
        else
            $display("escape_sequence_decoder regression: fail");
        $finish;
    end

endmodule
